// ===== rtl/core/gtm_pkg.sv =====
// Shared types, constants and the microcode program of the tetra mesh walker.
// No dependencies; used by gtm_sequencer, gtm_datapath and the top level.
`default_nettype none
package gtm_pkg;

    localparam int CFG_W   = 7;   // width of a node count register
    localparam int IDX_W   = 2;   // width of a register index
    localparam int ID_W    = 18;  // width of a linear node id
    localparam int FLAG_W  = 4;
    localparam int SLOT_W  = 3;
    localparam int STEP_W  = 4;
    localparam int NYZ_W   = 2 * CFG_W;
    localparam int TDATA_W = 80;  // four ids and the flags, padded to bytes
    localparam int TUSER_W = 4;

    localparam logic [IDX_W-1:0] REG_NODES_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_NODES_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_NODES_Z = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd4;

    typedef enum logic [2:0] {
        OP_LOAD,   // take a request, apply restart
        OP_NYZ,    // ny * nz
        OP_XMUL,   // x * ny * nz
        OP_YMUL,   // y * nz
        OP_SUM,    // base id, combined offset, end-of-mesh flag
        OP_EMIT    // load one tetrahedron into the output register
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE, // advance at once
        COND_IN,   // advance on an accepted request
        COND_OUT   // advance when the output register is free
    } cond_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        cond_t             cond;
        logic [STEP_W-1:0] next;
    } ctrl_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic              adv;
    } seq_out_t;

    typedef struct packed {
        logic s_valid;
        logic out_free;
    } seq_stat_t;

    // Control store: one word per step.
    function automatic ctrl_t rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{op: OP_LOAD, slot: 3'd0, cond: COND_IN, next: 4'd1};
        case (step)
            4'd0: w = '{op: OP_LOAD, slot: 3'd0, cond: COND_IN,   next: 4'd1};
            4'd1: w = '{op: OP_NYZ,  slot: 3'd0, cond: COND_NONE, next: 4'd2};
            4'd2: w = '{op: OP_XMUL, slot: 3'd0, cond: COND_NONE, next: 4'd3};
            4'd3: w = '{op: OP_YMUL, slot: 3'd0, cond: COND_NONE, next: 4'd4};
            4'd4: w = '{op: OP_SUM,  slot: 3'd0, cond: COND_NONE, next: 4'd5};
            4'd5: w = '{op: OP_EMIT, slot: 3'd0, cond: COND_OUT,  next: 4'd6};
            4'd6: w = '{op: OP_EMIT, slot: 3'd1, cond: COND_OUT,  next: 4'd7};
            4'd7: w = '{op: OP_EMIT, slot: 3'd2, cond: COND_OUT,  next: 4'd8};
            4'd8: w = '{op: OP_EMIT, slot: 3'd3, cond: COND_OUT,  next: 4'd9};
            4'd9: w = '{op: OP_EMIT, slot: 3'd4, cond: COND_OUT,  next: 4'd0};
            default: w = '{op: OP_LOAD, slot: 3'd0, cond: COND_IN, next: 4'd1};
        endcase
        return w;
    endfunction

    // Corner code of a tetrahedron: bit 2 x offset, bit 1 y offset, bit 0 z offset.
    function automatic logic [2:0] corner_code(input logic [SLOT_W-1:0] slot,
                                               input logic [1:0] k);
        logic [11:0] row;
        row = {3'd4, 3'd2, 3'd1, 3'd0};
        case (slot)
            3'd0: row = {3'd4, 3'd2, 3'd1, 3'd0};
            3'd1: row = {3'd7, 3'd2, 3'd3, 3'd1};
            3'd2: row = {3'd7, 3'd6, 3'd4, 3'd2};
            3'd3: row = {3'd7, 3'd5, 3'd1, 3'd4};
            3'd4: row = {3'd7, 3'd1, 3'd2, 3'd4};
            default: row = {3'd4, 3'd2, 3'd1, 3'd0};
        endcase
        return row[k*3 +: 3];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gtm_sequencer.sv =====
// Step counter and control store lookup of the tetra mesh walker.
// Depends on gtm_pkg (control word, program).
`default_nettype none
module gtm_sequencer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gtm_pkg::seq_stat_t stat,
    output gtm_pkg::seq_out_t      seq,
    output logic                   in_ready
);

    logic [gtm_pkg::STEP_W-1:0] step_reg;
    logic [gtm_pkg::STEP_W-1:0] step_next;
    gtm_pkg::ctrl_t             word;
    logic                       adv;

    assign word = gtm_pkg::rom(step_reg);

    always_comb
    begin
        case (word.cond)
            gtm_pkg::COND_NONE: adv = 1'b1;
            gtm_pkg::COND_IN:   adv = stat.s_valid;
            gtm_pkg::COND_OUT:  adv = stat.out_free;
            default:            adv = 1'b0;
        endcase
        step_next = adv ? word.next : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    assign seq.op   = word.op;
    assign seq.slot = word.slot;
    assign seq.adv  = adv;
    assign in_ready = (word.cond == gtm_pkg::COND_IN);

endmodule
`default_nettype wire

// ===== rtl/core/gtm_datapath.sv =====
// Cube indices, node id arithmetic and the output register of the walker.
// Depends on gtm_pkg; driven by gtm_sequencer.
`default_nettype none
module gtm_datapath #(
    parameter int MAX_NODES_PER_AXIS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gtm_pkg::seq_out_t             seq,
    input  wire logic                          restart,
    input  wire logic [gtm_pkg::CFG_W-1:0]     nodes_x,
    input  wire logic [gtm_pkg::CFG_W-1:0]     nodes_y,
    input  wire logic [gtm_pkg::CFG_W-1:0]     nodes_z,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [gtm_pkg::TDATA_W-1:0]        m_tdata,
    output logic [gtm_pkg::TUSER_W-1:0]        m_tuser,
    output logic                               m_tlast,
    output logic                               out_free
);

    localparam int CW   = (MAX_NODES_PER_AXIS > 2) ? $clog2(MAX_NODES_PER_AXIS) : 1;
    localparam int CMPW = (CW > gtm_pkg::CFG_W) ? CW : gtm_pkg::CFG_W;
    localparam int XPW  = CW + gtm_pkg::NYZ_W;
    localparam int YPW  = CW + gtm_pkg::CFG_W;
    localparam int ID_W = gtm_pkg::ID_W;

    function automatic logic [gtm_pkg::CFG_W-1:0] eff_n(input logic [gtm_pkg::CFG_W-1:0] v);
        logic [gtm_pkg::CFG_W-1:0] r;
        r = v;
        if (v < gtm_pkg::CFG_W'(2))
            r = gtm_pkg::CFG_W'(2);
        else if (int'(v) > MAX_NODES_PER_AXIS)
            r = gtm_pkg::CFG_W'(MAX_NODES_PER_AXIS);
        return r;
    endfunction

    logic [gtm_pkg::CFG_W-1:0] ny, nz;
    logic [CMPW-1:0]           lx, ly, lz;
    logic [CMPW-1:0]           xe, ye, ze;

    logic [CW-1:0]             cube_x_reg, cube_y_reg, cube_z_reg;
    logic [CW-1:0]             cube_x_next, cube_y_next, cube_z_next;
    logic [gtm_pkg::NYZ_W-1:0] nyz_reg;
    logic [ID_W-1:0]           acc_reg, term_reg, base_reg, offxy_reg;
    logic                      end_reg;

    logic [XPW-1:0]            xprod;
    logic [YPW-1:0]            yprod;

    logic                      out_valid_reg;
    logic [ID_W-1:0]           corner_reg [4];
    logic [gtm_pkg::FLAG_W-1:0] flags_reg;
    logic [gtm_pkg::SLOT_W-1:0] slot_reg;
    logic                      mesh_end_reg;

    logic [ID_W-1:0]           corner_id [4];
    logic [gtm_pkg::FLAG_W-1:0] flags;
    logic                      emit_fire, load_fire, beyond;

    assign ny = eff_n(nodes_y);
    assign nz = eff_n(nodes_z);
    assign lx = CMPW'(eff_n(nodes_x) - gtm_pkg::CFG_W'(2));
    assign ly = CMPW'(ny - gtm_pkg::CFG_W'(2));
    assign lz = CMPW'(nz - gtm_pkg::CFG_W'(2));
    assign xe = CMPW'(cube_x_reg);
    assign ye = CMPW'(cube_y_reg);
    assign ze = CMPW'(cube_z_reg);

    assign xprod = XPW'(cube_x_reg) * XPW'(nyz_reg);
    assign yprod = YPW'(cube_y_reg) * YPW'(nz);

    assign load_fire = seq.adv && (seq.op == gtm_pkg::OP_LOAD);
    assign emit_fire = seq.adv && (seq.op == gtm_pkg::OP_EMIT);
    assign beyond    = (xe > lx) || (ye > ly) || (ze > lz);
    assign out_free  = !out_valid_reg || m_tready;

    // Corner id: base plus the x, y and z strides picked by the corner code.
    always_comb
    begin
        logic [2:0]      code;
        logic [ID_W-1:0] off;
        for (int k = 0; k < 4; k++)
        begin
            code = gtm_pkg::corner_code(seq.slot, 2'(k));
            case (code[2:1])
                2'b00:   off = '0;
                2'b01:   off = ID_W'(nz);
                2'b10:   off = ID_W'(nyz_reg);
                default: off = offxy_reg;
            endcase
            corner_id[k] = base_reg + off + ID_W'(code[0]);
        end
    end

    always_comb
    begin
        flags = '0;
        case (seq.slot)
            3'd0: flags = {xe == '0, ye == '0, ze == '0, 1'b0};
            3'd1: flags = {xe == '0, ze == lz, 1'b0, ye == ly};
            3'd2: flags = {ze == '0, 1'b0, ye == ly, xe == lx};
            3'd3: flags = {ye == '0, 1'b0, xe == lx, ze == lz};
            default: flags = '0;
        endcase
    end

    // Walk order: z fastest; cube 0 on restart or after the last cube.
    always_comb
    begin
        cube_x_next = cube_x_reg;
        cube_y_next = cube_y_reg;
        cube_z_next = cube_z_reg;
        if (load_fire && (restart || beyond))
        begin
            cube_x_next = '0;
            cube_y_next = '0;
            cube_z_next = '0;
        end
        else if (emit_fire && (seq.slot == gtm_pkg::LAST_SLOT))
        begin
            if (end_reg)
            begin
                cube_x_next = '0;
                cube_y_next = '0;
                cube_z_next = '0;
            end
            else if (ze < lz)
                cube_z_next = cube_z_reg + CW'(1);
            else
            begin
                cube_z_next = '0;
                if (ye < ly)
                    cube_y_next = cube_y_reg + CW'(1);
                else
                begin
                    cube_y_next = '0;
                    cube_x_next = cube_x_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_x_reg    <= '0;
            cube_y_reg    <= '0;
            cube_z_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cube_x_reg <= cube_x_next;
            cube_y_reg <= cube_y_next;
            cube_z_reg <= cube_z_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.adv)
        begin
            case (seq.op)
                gtm_pkg::OP_NYZ:  nyz_reg <= gtm_pkg::NYZ_W'(ny) * gtm_pkg::NYZ_W'(nz);
                gtm_pkg::OP_XMUL: acc_reg <= ID_W'(xprod);
                gtm_pkg::OP_YMUL: term_reg <= ID_W'(yprod);
                gtm_pkg::OP_SUM:
                begin
                    base_reg  <= acc_reg + term_reg + ID_W'(cube_z_reg);
                    offxy_reg <= ID_W'(nyz_reg) + ID_W'(nz);
                    end_reg   <= (xe == lx) && (ye == ly) && (ze == lz);
                end
                gtm_pkg::OP_EMIT:
                begin
                    for (int k = 0; k < 4; k++)
                        corner_reg[k] <= corner_id[k];
                    flags_reg    <= flags;
                    slot_reg     <= seq.slot;
                    mesh_end_reg <= end_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gtm_pkg::TDATA_W'({flags_reg, corner_reg[3], corner_reg[2],
                                         corner_reg[1], corner_reg[0]});
    assign m_tuser  = {mesh_end_reg, slot_reg};
    assign m_tlast  = (slot_reg == gtm_pkg::LAST_SLOT);

endmodule
`default_nettype wire

// ===== rtl/core/grid_tetra_mesh_generator_unit.sv =====
// Top level of the structured-grid tetra mesh walker: ports, node count registers,
// sequencer and datapath. Depends on gtm_pkg, gtm_sequencer, gtm_datapath.
//
//  channel  | signals                              | direction | moves
//  ---------+--------------------------------------+-----------+---------------------
//  s_*      | s_tvalid s_tready s_tdata            | in        | one walk request
//  m_*      | m_tvalid m_tready m_tdata m_tuser    | out       | five tetrahedra
//           | m_tlast                              |           | per request
//  cfg_*    | cfg_valid cfg_ready cfg_index        | in        | node count writes
//           | cfg_data                             |           |
//
// A request runs through one accept step,
// four arithmetic steps (grid stride, x and y products, id sum), five emit steps.
// Each emit step holds while the output register is full and not taken.
// The microcode program sets these steps; s_tready is high only in the accept step.
// Reset clears the step counter, cube indices and output valid, and sets every
// node count to 2. Configuration writes are taken every cycle.
`default_nettype none
module grid_tetra_mesh_generator_unit #(
    parameter int MAX_NODES_PER_AXIS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [0] restart, [7:1] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [17:0] corner_a, [35:18] corner_b, [53:36] corner_c, [71:54] corner_d,
    // [75:72] face_flags, [79:76] zero
    output logic [gtm_pkg::TDATA_W-1:0]        m_tdata,
    output logic [gtm_pkg::TUSER_W-1:0]        m_tuser,   // [2:0] tetra_slot, [3] mesh_end
    output logic                               m_tlast,   // last_of_cube
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gtm_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [gtm_pkg::CFG_W-1:0]     cfg_data
);

    logic [gtm_pkg::CFG_W-1:0] nodes_x_reg, nodes_y_reg, nodes_z_reg;
    gtm_pkg::seq_out_t         seq;
    gtm_pkg::seq_stat_t        stat;
    logic                      out_free;

    assign cfg_ready = 1'b1;

    // Hold the raw node counts; the datapath clamps them on use. Drop writes to
    // an index past the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_x_reg <= gtm_pkg::CFG_W'(2);
            nodes_y_reg <= gtm_pkg::CFG_W'(2);
            nodes_z_reg <= gtm_pkg::CFG_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gtm_pkg::REG_NODES_X: nodes_x_reg <= cfg_data;
                gtm_pkg::REG_NODES_Y: nodes_y_reg <= cfg_data;
                gtm_pkg::REG_NODES_Z: nodes_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign stat.s_valid  = s_tvalid;
    assign stat.out_free = out_free;

    // Advance through the program: accept, arithmetic, then five emits.
    gtm_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .seq      (seq),
        .in_ready (s_tready)
    );

    gtm_datapath #(
        .MAX_NODES_PER_AXIS (MAX_NODES_PER_AXIS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .seq      (seq),
        .restart  (s_tdata[0]),
        .nodes_x  (nodes_x_reg),
        .nodes_y  (nodes_y_reg),
        .nodes_z  (nodes_z_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .out_free (out_free)
    );

`ifndef SYNTHESIS
    // The sequencer leaves the accept step right after a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted twice in a row");

    // tlast marks exactly the fifth tetrahedron.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[2:0] == gtm_pkg::LAST_SLOT)))
        else $error("tlast does not match tetra slot");

    // Slot never leaves the range of one cube.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2:0] <= gtm_pkg::LAST_SLOT))
        else $error("tetra slot out of range");
`endif

endmodule
`default_nettype wire
